>>> src/iatr_pkg.sv
// ----------------------------------------------------------------------------
// I/O access trace ring: shared types and constants
// Request and response formats, entry layout, status codes and the address
// filter used by the trace ring.
// ----------------------------------------------------------------------------
package iatr_pkg;

  localparam int TRACE_DEPTH = 256;
  localparam int IDX_W       = (TRACE_DEPTH > 2) ? $clog2(TRACE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TRACE_DEPTH + 1);
  localparam int POS_W       = 8;
  localparam int SUM_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  localparam logic [31:0] IO_BASE    = 32'h1F80_1000;
  localparam logic [31:0] MARKER_LOW = 32'hF000_0000;
  localparam logic [31:0] IO_SPAN    = 32'h0000_1000;

  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_FILTERED = 3'd0;
  localparam logic [2:0] ST_MERGED   = 3'd1;
  localparam logic [2:0] ST_APPENDED = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_READ_BAD = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [31:0]      access_addr;
    logic [31:0]      access_value;
    logic             access_is_write;
    logic [2:0]       access_bytes;
    logic [POS_W-1:0] read_position;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      entry_addr;
    logic [31:0]      entry_value;
    logic             entry_is_write;
    logic [2:0]       entry_bytes;
    logic [31:0]      entry_repeats;
    logic [CNT_W-1:0] fill_level;
  } rsp_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] value;
    logic [31:0] repeats;
    logic        is_write;
    logic [2:0]  bytes;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] fill_level;
  } rsp_meta_t;

  function automatic logic passes_filter(input logic [31:0] addr);
    logic [31:0] off;
    logic        hit;
    off = addr - IO_BASE;
    hit = ((off >= 32'h070) && (off < 32'h078)) ||
          ((off >= 32'h080) && (off < 32'h100)) ||
          ((off >= 32'h100) && (off < 32'h130)) ||
          ((off >= 32'h800) && (off < 32'h804)) ||
          ((off >= 32'h810) && (off < 32'h818));
    return (addr >= MARKER_LOW) || ((off < IO_SPAN) && hit);
  endfunction

endpackage

>>> src/io_access_trace_ring.sv
// ----------------------------------------------------------------------------
// I/O access trace ring
// Filters bus accesses, merges repeats into the newest entry and keeps the
// rest in a ring that overwrites its oldest entry; entries read oldest first.
// ----------------------------------------------------------------------------
// One request is taken per cycle while no response is held back; its response
// appears in the response register in the cycle after the transfer. Entries
// live in a single memory with a registered read port; a read request fetches
// its entry in its transfer cycle, and the newest entry is also held in registers
// so a merge writes the memory without reading it first. A response held back
// by stall stalls the request side until it is taken. There is no clearing pass after reset.
module io_access_trace_ring
  import iatr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ram_ctl_t  ram_ctl;
  rsp_meta_t meta;
  entry_t    rd_entry;
  logic      read_ok;

  iatr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .meta      (meta),
    .ram_ctl   (ram_ctl)
  );

  iatr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .re    (ram_ctl.re),
    .raddr (ram_ctl.raddr),
    .rdata (rd_entry)
  );

  assign read_ok = (meta.status == ST_READ_OK);

  always_comb begin
    rsp.status         = meta.status;
    rsp.fill_level     = meta.fill_level;
    rsp.entry_addr     = read_ok ? rd_entry.addr : '0;
    rsp.entry_value    = read_ok ? rd_entry.value : '0;
    rsp.entry_is_write = read_ok ? rd_entry.is_write : 1'b0;
    rsp.entry_bytes    = read_ok ? rd_entry.bytes : '0;
    rsp.entry_repeats  = read_ok ? rd_entry.repeats : '0;
  end

endmodule

>>> src/iatr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module iatr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/iatr_ctrl.sv
// ----------------------------------------------------------------------------
// I/O access trace ring: request control
// Decodes requests, keeps the ring pointers and a register copy of the newest
// entry, drives the entry memory and holds the response status register.
// ----------------------------------------------------------------------------
module iatr_ctrl
  import iatr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_t      req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_meta_t meta,
  output ram_ctl_t  ram_ctl
);

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] last_index;
  logic [IDX_W-1:0] last_index_next;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  entry_t           newest;
  entry_t           newest_next;
  rsp_meta_t        meta_next;
  logic             accept;
  logic             hit;
  logic [SUM_W-1:0] pos_sum;
  logic [SUM_W-1:0] pos_idx;
  logic             pos_ok;
  entry_t           fresh;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign hit = (entry_count != '0) && (newest.addr == req.access_addr) &&
               (newest.is_write == req.access_is_write);

  assign pos_ok  = SUM_W'(req.read_position) < SUM_W'(entry_count);
  assign pos_sum = SUM_W'(write_index) + SUM_W'(req.read_position) - SUM_W'(entry_count);
  assign pos_idx = pos_sum[SUM_W-1] ? (pos_sum + SUM_W'(TRACE_DEPTH)) : pos_sum;

  always_comb begin
    fresh.addr     = req.access_addr;
    fresh.value    = req.access_value;
    fresh.repeats  = '0;
    fresh.is_write = req.access_is_write;
    fresh.bytes    = req.access_bytes;
  end

  always_comb begin
    write_index_next = write_index;
    last_index_next  = last_index;
    entry_count_next = entry_count;
    newest_next      = newest;
    meta_next.status = ST_FILTERED;
    ram_ctl.we       = 1'b0;
    ram_ctl.waddr    = write_index;
    ram_ctl.wdata    = fresh;
    ram_ctl.re       = 1'b0;
    ram_ctl.raddr    = pos_idx[IDX_W-1:0];
    unique case (req.req_type)
      REQ_RECORD: begin
        if (passes_filter(req.access_addr)) begin
          if (hit) begin
            newest_next.repeats = newest.repeats + 32'd1;
            newest_next.value   = req.access_value;
            ram_ctl.we          = accept;
            ram_ctl.waddr       = last_index;
            ram_ctl.wdata       = newest_next;
            meta_next.status    = ST_MERGED;
          end else begin
            newest_next      = fresh;
            ram_ctl.we       = accept;
            last_index_next  = write_index;
            write_index_next = (write_index == IDX_W'(TRACE_DEPTH - 1)) ? '0 :
                               write_index + IDX_W'(1);
            if (entry_count != CNT_W'(TRACE_DEPTH)) begin
              entry_count_next = entry_count + CNT_W'(1);
            end
            meta_next.status = ST_APPENDED;
          end
        end
      end
      REQ_READ: begin
        if (pos_ok) begin
          ram_ctl.re       = accept;
          meta_next.status = ST_READ_OK;
        end else begin
          meta_next.status = ST_READ_BAD;
        end
      end
      REQ_CLEAR: begin
        write_index_next = '0;
        entry_count_next = '0;
        meta_next.status = ST_CLEARED;
      end
      default: begin
        meta_next.status = ST_FILTERED;
      end
    endcase
    meta_next.fill_level = entry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      last_index  <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        write_index <= write_index_next;
        last_index  <= last_index_next;
        entry_count <= entry_count_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newest <= newest_next;
      meta   <= meta_next;
    end
  end

endmodule

>>> src/iatr_checker.sv
// ----------------------------------------------------------------------------
// I/O access trace ring: port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module iatr_checker
  import iatr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled response must hold until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // The fill level never exceeds the ring depth.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fill_level <= CNT_W'(TRACE_DEPTH))
    else $error("fill level above ring depth");

  // A successful read needs at least one held entry, and a clear empties the ring.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_READ_OK) |-> rsp.fill_level != '0)
    else $error("read succeeded on an empty ring");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_CLEARED) |-> rsp.fill_level == '0)
    else $error("clear left entries behind");

  // Entry fields are zero for every response other than a successful read.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_READ_OK) |->
      (rsp.entry_addr == '0) && (rsp.entry_value == '0) && !rsp.entry_is_write &&
      (rsp.entry_bytes == '0) && (rsp.entry_repeats == '0))
    else $error("entry fields set outside a successful read");

endmodule

bind io_access_trace_ring iatr_checker u_iatr_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the I/O access trace ring
// Drives record, read, clear and unused requests through the valid/stall
// request channel and checks every response transfer against a shadow trace
// ring kept in the testbench, with random idling on both channels, a long
// response hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import iatr_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         RANDOM_REQS = 1780;
  localparam int         TAIL_ITEMS  = 200;
  localparam int         HOLD_AT     = 700;
  localparam int         HOLD_LEN    = 150;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct {
    bit   wait_drain;
    req_t r;
  } pending_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic tail_mode = 1'b0;

  pending_t pending[$];
  rsp_t     expected_rsp[$];

  entry_t shadow_ring[TRACE_DEPTH];
  int     shadow_wr  = 0;
  int     shadow_cnt = 0;

  int mismatch_cnt = 0;
  int accepted_cnt = 0;
  int gap_cnt      = 0;
  int hold_cnt     = 0;
  bit hold_done    = 1'b0;
  int burst_cnt    = 0;
  int cycle_cnt    = 0;

  io_access_trace_ring uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit in_trace_window(logic [31:0] a);
    logic [31:0] ofs;
    ofs = a - IO_BASE;
    if (a >= MARKER_LOW) return 1'b1;
    if (ofs >= IO_SPAN) return 1'b0;
    return (ofs >= 32'h070 && ofs < 32'h078) || (ofs >= 32'h080 && ofs < 32'h130) ||
           (ofs >= 32'h800 && ofs < 32'h804) || (ofs >= 32'h810 && ofs < 32'h818);
  endfunction

  function automatic rsp_t trace_predict(req_t r);
    rsp_t o;
    int   newest;
    int   slot;
    o = '0;
    case (r.req_type)
      REQ_RECORD: begin
        newest = (shadow_wr + TRACE_DEPTH - 1) % TRACE_DEPTH;
        if (!in_trace_window(r.access_addr)) begin
          o.status = ST_FILTERED;
        end else if (shadow_cnt != 0 && shadow_ring[newest].addr == r.access_addr &&
                     shadow_ring[newest].is_write == r.access_is_write) begin
          shadow_ring[newest].repeats = shadow_ring[newest].repeats + 32'd1;
          shadow_ring[newest].value   = r.access_value;
          o.status = ST_MERGED;
        end else begin
          shadow_ring[shadow_wr].addr     = r.access_addr;
          shadow_ring[shadow_wr].value    = r.access_value;
          shadow_ring[shadow_wr].repeats  = '0;
          shadow_ring[shadow_wr].is_write = r.access_is_write;
          shadow_ring[shadow_wr].bytes    = r.access_bytes;
          shadow_wr = (shadow_wr + 1) % TRACE_DEPTH;
          if (shadow_cnt < TRACE_DEPTH) shadow_cnt++;
          o.status = ST_APPENDED;
        end
      end
      REQ_READ: begin
        if (int'(r.read_position) < shadow_cnt) begin
          slot = (shadow_wr + TRACE_DEPTH - shadow_cnt + int'(r.read_position)) % TRACE_DEPTH;
          o.entry_addr     = shadow_ring[slot].addr;
          o.entry_value    = shadow_ring[slot].value;
          o.entry_is_write = shadow_ring[slot].is_write;
          o.entry_bytes    = shadow_ring[slot].bytes;
          o.entry_repeats  = shadow_ring[slot].repeats;
          o.status = ST_READ_OK;
        end else begin
          o.status = ST_READ_BAD;
        end
      end
      REQ_CLEAR: begin
        shadow_cnt = 0;
        shadow_wr  = 0;
        o.status = ST_CLEARED;
      end
      default: o.status = ST_FILTERED;
    endcase
    o.fill_level = CNT_W'(shadow_cnt);
    return o;
  endfunction

  function automatic req_t random_req(logic [1:0] kind);
    req_t r;
    r.req_type        = kind;
    r.access_addr     = $urandom;
    r.access_value    = $urandom;
    r.access_is_write = 1'($urandom_range(0, 1));
    r.access_bytes    = 3'($urandom_range(0, 7));
    r.read_position   = POS_W'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [31:0] traced_addr();
    case ($urandom_range(0, 4))
      0: return IO_BASE + 32'h070 + $urandom_range(0, 7);
      1: return IO_BASE + 32'h080 + $urandom_range(0, 32'hAF);
      2: return IO_BASE + 32'h800 + $urandom_range(0, 3);
      3: return IO_BASE + 32'h810 + $urandom_range(0, 7);
      default: return MARKER_LOW | $urandom;
    endcase
  endfunction

  function automatic logic [31:0] stray_addr();
    case ($urandom_range(0, 9))
      0: return IO_BASE + 32'h06F;
      1: return IO_BASE + 32'h078;
      2: return IO_BASE + 32'h07F;
      3: return IO_BASE + 32'h130;
      4: return IO_BASE + 32'h804;
      5: return IO_BASE + 32'h80F;
      6: return IO_BASE + 32'h818;
      7: return IO_BASE - $urandom_range(1, 64);
      8: return IO_BASE + IO_SPAN + $urandom_range(0, 32'hFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_record(logic [31:0] addr, logic [31:0] value, logic dir,
                            logic [2:0] nbytes);
    pending_t p;
    p.wait_drain          = 1'b0;
    p.r                   = random_req(REQ_RECORD);
    p.r.access_addr       = addr;
    p.r.access_value      = value;
    p.r.access_is_write   = dir;
    p.r.access_bytes      = nbytes;
    pending.push_back(p);
  endtask

  task automatic add_request(logic [1:0] kind, logic [POS_W-1:0] pos);
    pending_t p;
    p.wait_drain      = 1'b0;
    p.r               = random_req(kind);
    p.r.read_position = pos;
    pending.push_back(p);
  endtask

  task automatic note_mismatch(string what, rsp_t got, rsp_t want);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s: status %0d/%0d addr %h/%h value %h/%h dir %0d/%0d",
               what, got.status, want.status, got.entry_addr, want.entry_addr,
               got.entry_value, want.entry_value, got.entry_is_write, want.entry_is_write);
      $display("  bytes %0d/%0d repeats %0d/%0d fill %0d/%0d (actual/expected)",
               got.entry_bytes, want.entry_bytes, got.entry_repeats, want.entry_repeats,
               got.fill_level, want.fill_level);
    end
  endtask

  always @(posedge clk) begin : drive_proc
    pending_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      gap_cnt = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(trace_predict(req));
        accepted_cnt++;
      end
      if (req_valid && req_stall) begin
        req_valid <= 1'b1;
      end else if (gap_cnt != 0) begin
        gap_cnt--;
        req_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        req_valid <= 1'b0;
      end else if (pending[0].wait_drain && expected_rsp.size() != 0) begin
        req_valid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        req       <= nxt.r;
        req_valid <= 1'b1;
        if (!tail_mode && $urandom_range(0, 9) == 0) gap_cnt = $urandom_range(1, 11);
      end
    end
    tail_mode <= (pending.size() < TAIL_ITEMS);
  end

  always @(posedge clk) begin : stall_proc
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_cnt  = 0;
      burst_cnt = 0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      rsp_stall <= 1'b1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN - 1;
      rsp_stall <= 1'b1;
    end else if (tail_mode) begin
      rsp_stall <= 1'b0;
    end else if (burst_cnt != 0) begin
      burst_cnt--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_cnt = $urandom_range(0, 10);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_proc
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        note_mismatch("unexpected response", rsp, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status || rsp.entry_addr !== want.entry_addr ||
            rsp.entry_value !== want.entry_value ||
            rsp.entry_is_write !== want.entry_is_write ||
            rsp.entry_bytes !== want.entry_bytes ||
            rsp.entry_repeats !== want.entry_repeats ||
            rsp.fill_level !== want.fill_level) begin
          note_mismatch("response mismatch", rsp, want);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stim_proc
    pending_t    p;
    logic [31:0] last_addr;
    logic        last_dir;
    int          roll;

    add_request(REQ_READ, 8'd0);
    add_record(32'h0000_0000, $urandom, 1'b0, 3'd1);
    add_record(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 3'd0);
    add_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 3'd7);
    add_record(32'hFFFF_FFFF, $urandom, 1'b1, 3'd4);
    add_record(MARKER_LOW - 32'd1, $urandom, 1'b1, 3'd2);
    add_record(MARKER_LOW, $urandom, 1'b0, 3'd4);
    add_record(IO_BASE - 32'd1, $urandom, 1'b0, 3'd4);
    add_record(IO_BASE + 32'h070, $urandom, 1'b1, 3'd1);
    add_record(IO_BASE + 32'h077, $urandom, 1'b0, 3'd1);
    add_record(IO_BASE + 32'h078, $urandom, 1'b0, 3'd2);
    add_record(IO_BASE + 32'h12F, $urandom, 1'b1, 3'd1);
    add_record(IO_BASE + 32'h130, $urandom, 1'b1, 3'd4);
    add_record(IO_BASE + 32'h803, $urandom, 1'b0, 3'd2);
    add_record(IO_BASE + 32'h804, $urandom, 1'b0, 3'd4);
    add_record(IO_BASE + 32'h817, $urandom, 1'b1, 3'd4);
    add_record(IO_BASE + 32'h818, $urandom, 1'b1, 3'd4);
    add_request(REQ_READ, 8'd0);
    add_request(REQ_READ, 8'd7);
    add_request(REQ_READ, 8'd8);
    add_request(REQ_READ, 8'd255);
    add_request(REQ_UNUSED, 8'd0);
    add_request(REQ_CLEAR, 8'd0);
    add_request(REQ_READ, 8'd0);
    add_record(IO_BASE + 32'h810, $urandom, 1'b0, 3'd4);
    add_request(REQ_READ, 8'd0);

    last_addr = IO_BASE + 32'h810;
    last_dir  = 1'b0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      p.wait_drain = (i == 400 || i == 1200);
      p.r = random_req(REQ_RECORD);
      if (i == 1300 || (i > 700 && $urandom_range(0, 299) == 0)) begin
        p.r.req_type = REQ_CLEAR;
      end else if (roll < 25) begin
        if ($urandom_range(0, 7) == 0) last_dir = ~last_dir;
        p.r.access_addr     = last_addr;
        p.r.access_is_write = last_dir;
      end else if (roll < 65) begin
        last_addr = traced_addr();
        last_dir  = p.r.access_is_write;
        p.r.access_addr = last_addr;
      end else if (roll < 75) begin
        p.r.access_addr = stray_addr();
      end else if (roll < 97) begin
        p.r.req_type = REQ_READ;
        if ($urandom_range(0, 1) == 0) p.r.read_position = POS_W'($urandom_range(0, 15));
      end else begin
        p.r.req_type = REQ_UNUSED;
      end
      pending.push_back(p);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && expected_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
